[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CHECK(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

[src/pcwa_pkg.sv]
// ----------------------------------------------------------------------------
// Power channel window averager package
// Shared widths, scaling constants, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package pcwa_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned QuotW    = 24;
  localparam int unsigned DivisorW = 20;
  localparam int unsigned RsenseW  = 20;
  localparam int unsigned AvgCfgW  = 11;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned ProdW    = 35;

  localparam logic [18:0]        SENSE_SCALE = 19'd390625;
  localparam logic [6:0]         VOLT_SCALE  = 7'd125;
  localparam logic [SampleW-1:0] SAMPLE_MAX  = 24'hFFFFFF;
  localparam logic [15:0]        OUT_MAX     = 16'hFFFF;
  localparam logic [RsenseW-1:0] RSENSE_RST  = 20'd15000;
  localparam logic [AvgCfgW-1:0] AVG_RST     = 11'd500;

  localparam logic [0:0] REG_RSENSE = 1'b0;
  localparam logic [0:0] REG_AVG    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SDIV,
    S_SWAIT,
    S_WRITE,
    S_WALK,
    S_MEAN,
    S_MWAIT,
    S_POW,
    S_DONE
  } pcwa_state_e;

endpackage

[src/pcwa_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Produces a quotient of QuotW bits, one bit per cycle, for a dividend whose
// quotient is known to fit. A one-cycle done pulse marks a valid quotient.
// ----------------------------------------------------------------------------
module pcwa_div #(
  parameter int unsigned DIV_W = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIV_W-1:0]              dividend_i,
  input  logic [pcwa_pkg::DivisorW-1:0] divisor_i,
  output logic                          done_o,
  output logic [pcwa_pkg::QuotW-1:0]    quot_o
);
  import pcwa_pkg::*;

  localparam int unsigned RemW = DivisorW + 1;
  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [QuotW-1:0]    low_q, low_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [RemW-1:0]     trial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    low_d  = low_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[RemW-2:0], low_q[QuotW-1]};
    if (start_i) begin
      cnt_d = CntW'(QuotW);
      rem_d = RemW'(dividend_i[DIV_W-1:QuotW]);
      low_d = dividend_i[QuotW-1:0];
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        low_d = {low_q[QuotW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        low_d = {low_q[QuotW-2:0], 1'b0};
      end
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

[src/power_channel_window_averager.sv]
// ----------------------------------------------------------------------------
// Power channel window averager
// Converts raw bus and sense voltage words into a sample current per channel,
// keeps each channel's samples in a ring memory and reports the latest
// voltage, the windowed mean current and the power.
// ----------------------------------------------------------------------------
// The window length n is average_count, with zero read as one and values
// above the ring depth read as the depth. The window walk reads the ring
// memory once per cycle, and the shared divider works out first the sample
// current and then the mean. Samples for a channel outside the configured
// count are answered with zero figures. A result may wait at the output while
// the next sample is taken. No clearing pass is needed after reset: a fill
// count per channel marks which ring entries hold samples, and the others
// count as zero.
`include "assert_macros.svh"

module power_channel_window_averager #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned CHANNELS   = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [pcwa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    channel_i,
  input  logic [15:0]                   vbus_raw_i,
  input  logic [15:0]                   vsense_raw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    channel_out_o,
  output logic [14:0]                   voltage_mv_o,
  output logic [15:0]                   current_avg_ma_o,
  output logic [15:0]                   power_mw_o
);
  import pcwa_pkg::*;

  localparam int unsigned IdxW  = $clog2(RING_DEPTH);
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SumW  = SampleW + IdxW;
  localparam int unsigned MeanW = SumW - 8;
  localparam int unsigned DivW  = (MeanW > ProdW) ? MeanW : ProdW;
  localparam int unsigned SatW  = (SumW > ProdW + 9) ? SumW : ProdW + 9;

  pcwa_state_e state_q, state_d;

  logic [RsenseW-1:0] rs_q, rs_d;
  logic [AvgCfgW-1:0] avg_cfg_q, avg_cfg_d;

  logic [IdxW-1:0] ptr_q  [CHANNELS];
  logic [IdxW-1:0] ptr_d  [CHANNELS];
  logic [CntW-1:0] fill_q [CHANNELS];
  logic [CntW-1:0] fill_d [CHANNELS];

  logic            out_valid_q, out_valid_d;
  logic            rd_pend_q, rd_pend_d;

  logic [1:0]         ch_q, ch_d;
  logic [ChW-1:0]     chi_q, chi_d;
  logic [15:0]        vbus_q, vbus_d;
  logic [15:0]        vsense_q, vsense_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [SampleW-1:0] sample_q, sample_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    iss_q, iss_d;
  logic               rd_inc_q, rd_inc_d;
  logic [15:0]        avg_q, avg_d;
  logic [31:0]        pwp_q, pwp_d;
  logic [1:0]         out_ch_q, out_ch_d;
  logic [14:0]        out_volt_q, out_volt_d;
  logic [15:0]        out_avg_q, out_avg_d;
  logic [15:0]        out_pw_q, out_pw_d;

  logic [SampleW-1:0] ring_mem [CHANNELS][RING_DEPTH];
  logic [SampleW-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    ptr_cur, raddr;

  logic               div_start, div_done;
  logic [DivW-1:0]    div_dvd;
  logic [DivisorW-1:0] div_dsr;
  logic [QuotW-1:0]   div_quot;

  logic               in_xfer, ch_ok;
  logic [MeanW-1:0]   mean_dvd;
  logic               sat_s, sat_m;
  logic [22:0]        volt_prod;

  pcwa_div #(
    .DIV_W(DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    rs_d      = rs_q;
    avg_cfg_d = avg_cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RSENSE: rs_d      = cfg_wdata_i[RsenseW-1:0];
        REG_AVG:    avg_cfg_d = cfg_wdata_i[AvgCfgW-1:0];
        default:    rs_d      = rs_q;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ch_ok      = (32'(channel_i) < CHANNELS);
  assign ptr_cur    = ptr_q[chi_q];
  assign raddr      = ptr_cur - IdxW'(iss_q);
  assign mean_dvd   = sum_q[SumW-1:8];
  assign sat_s      = (SatW'(prod_q) >= SatW'({rs_q, 24'd0}));
  assign sat_m      = (SatW'(mean_dvd) >= SatW'({n_q, 16'd0}));
  assign volt_prod  = 23'(vbus_q) * 23'(VOLT_SCALE);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_pend_d   = rd_pend_q;
    ch_d        = ch_q;
    chi_d       = chi_q;
    vbus_d      = vbus_q;
    vsense_d    = vsense_q;
    prod_d      = prod_q;
    sample_d    = sample_q;
    sum_d       = sum_q;
    n_d         = n_q;
    iss_d       = iss_q;
    rd_inc_d    = rd_inc_q;
    avg_d       = avg_q;
    pwp_d       = pwp_q;
    out_ch_d    = out_ch_q;
    out_volt_d  = out_volt_q;
    out_avg_d   = out_avg_q;
    out_pw_d    = out_pw_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    div_dvd     = DivW'(prod_q);
    div_dsr     = rs_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          ch_d     = channel_i;
          chi_d    = ChW'(channel_i);
          vbus_d   = vbus_raw_i;
          vsense_d = vsense_raw_i;
          if (ch_ok) begin
            state_d = S_MUL;
          end else begin
            vbus_d  = '0;
            avg_d   = '0;
            pwp_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        prod_d = ProdW'(vsense_q) * ProdW'(SENSE_SCALE);
        ptr_d[chi_q] = ptr_q[chi_q] + 1'b1;
        if (fill_q[chi_q] != CntW'(RING_DEPTH)) begin
          fill_d[chi_q] = fill_q[chi_q] + 1'b1;
        end
        state_d = S_SDIV;
      end
      S_SDIV: begin
        if (sat_s) begin
          sample_d = SAMPLE_MAX;
          state_d  = S_WRITE;
        end else begin
          div_start = 1'b1;
          state_d   = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (div_done) begin
          sample_d = div_quot[SampleW-1:0];
          state_d  = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        sum_d     = SumW'(sample_q);
        iss_d     = CntW'(1);
        rd_pend_d = 1'b0;
        if (avg_cfg_q == '0) begin
          n_d = CntW'(1);
        end else if (32'(avg_cfg_q) > RING_DEPTH) begin
          n_d = CntW'(RING_DEPTH);
        end else begin
          n_d = CntW'(avg_cfg_q);
        end
        state_d = S_WALK;
      end
      S_WALK: begin
        if (rd_pend_q && rd_inc_q) begin
          sum_d = sum_q + SumW'(rdata_q);
        end
        if (iss_q < n_q) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_inc_d  = (iss_q < fill_q[chi_q]);
          iss_d     = iss_q + 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        div_dvd = DivW'(mean_dvd);
        div_dsr = DivisorW'(n_q);
        if (sat_m) begin
          avg_d   = OUT_MAX;
          state_d = S_POW;
        end else begin
          div_start = 1'b1;
          state_d   = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (div_done) begin
          avg_d   = div_quot[15:0];
          state_d = S_POW;
        end
      end
      S_POW: begin
        pwp_d   = 32'(vbus_q) * 32'(avg_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ch_d    = ch_q;
          out_volt_d  = volt_prod[22:8];
          out_avg_d   = avg_q;
          out_pw_d    = (pwp_q[31:27] != '0) ? OUT_MAX : pwp_q[26:11];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rs_q        <= RSENSE_RST;
      avg_cfg_q   <= AVG_RST;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        fill_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rs_q        <= rs_d;
      avg_cfg_q   <= avg_cfg_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    chi_q      <= chi_d;
    vbus_q     <= vbus_d;
    vsense_q   <= vsense_d;
    prod_q     <= prod_d;
    sample_q   <= sample_d;
    sum_q      <= sum_d;
    n_q        <= n_d;
    iss_q      <= iss_d;
    rd_inc_q   <= rd_inc_d;
    avg_q      <= avg_d;
    pwp_q      <= pwp_d;
    out_ch_q   <= out_ch_d;
    out_volt_q <= out_volt_d;
    out_avg_q  <= out_avg_d;
    out_pw_q   <= out_pw_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[chi_q][ptr_cur] <= sample_q;
    end
    if (mem_re) begin
      rdata_q <= ring_mem[chi_q][raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_out_o    = out_ch_q;
  assign voltage_mv_o     = out_volt_q;
  assign current_avg_ma_o = out_avg_q;
  assign power_mw_o       = out_pw_q;

  `ASSERT_IMPLY(a_fill_bound, state_q == S_WALK, fill_q[chi_q] <= CntW'(RING_DEPTH), "fill overflow")
  `ASSERT_IMPLY(a_walk_count, state_q == S_WALK, iss_q <= n_q && n_q != '0, "walk beyond window")
  `ASSERT_IMPLY(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "stray result")

endmodule
